// ----- hw/rtl/tip_pkg.sv -----
// tip_pkg: shared types, character codes and the digit decoder for the
// text to integer parser. No dependencies; used by every tip_* module.
package tip_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int RESULT_WIDTH    = 64;
  localparam int BASE_WIDTH      = 6;
  localparam int ADDR_WIDTH      = 3;
  localparam int DATA_WIDTH      = 32;

  // register index of number_base
  localparam logic REG_NUMBER_BASE = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [4:0] {
    PH_DONE   = 5'b00001,
    PH_SPACE  = 5'b00010,
    PH_PREFIX = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic                  negative;
    logic [BASE_WIDTH-1:0] base;
  } ctrl_t;

  typedef struct packed {
    logic                  alnum;
    logic [BASE_WIDTH-1:0] value;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d.alnum = 1'b1;
    d.value = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.value = BASE_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.value = BASE_WIDTH'(c - CH_LA) + BASE_DEC;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.value = BASE_WIDTH'(c - CH_UA) + BASE_DEC;
    end else begin
      d.alnum = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/tip_cfg_regs.sv -----
// tip_cfg_regs: APB register file holding number_base.
// Depends on tip_pkg.
module tip_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tip_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tip_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tip_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  output logic [tip_pkg::BASE_WIDTH-1:0] number_base
);

  logic sel_base;

  assign pready   = 1'b1;
  assign sel_base = (paddr[2] == tip_pkg::REG_NUMBER_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= tip_pkg::BASE_AUTO;
    end else if (psel && penable && pwrite && sel_base) begin
      number_base <= pwdata[tip_pkg::BASE_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_base) begin
      prdata = tip_pkg::DATA_WIDTH'(number_base);
    end
  end

endmodule

// ----- hw/rtl/tip_step_logic.sv -----
// tip_step_logic: next-state and result logic for one byte of the parse.
// Depends on tip_pkg.
module tip_step_logic #(
  parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = tip_pkg::COUNT_WIDTH_DEF
) (
  input  logic [7:0]                       char_in,
  input  logic                             first_char,
  input  logic [tip_pkg::BASE_WIDTH-1:0]   number_base,
  input  tip_pkg::ctrl_t                   ctrl,
  input  logic [VALUE_WIDTH-1:0]           acc,
  input  logic [COUNT_WIDTH-1:0]           cnt,
  output tip_pkg::ctrl_t                   ctrl_next,
  output logic [VALUE_WIDTH-1:0]           acc_next,
  output logic [COUNT_WIDTH-1:0]           cnt_next,
  output logic                             emit,
  output logic [tip_pkg::RESULT_WIDTH-1:0] parsed_value,
  output logic [COUNT_WIDTH-1:0]           chars_consumed
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  tip_pkg::ctrl_t                 eff;
  tip_pkg::digit_t                dg;
  logic [VALUE_WIDTH-1:0]         acc_e;
  logic [COUNT_WIDTH-1:0]         cnt_e;
  logic [COUNT_WIDTH-1:0]         cnt_p1;
  logic [COUNT_WIDTH-1:0]         cnt_p2;
  logic [tip_pkg::BASE_WIDTH-1:0] prefix_base;
  logic [tip_pkg::BASE_WIDTH-1:0] zero_base;
  logic [tip_pkg::BASE_WIDTH-1:0] dig_base;
  logic [VALUE_WIDTH+5:0]         prod;
  logic [VALUE_WIDTH-1:0]         mac;
  logic signed [VALUE_WIDTH-1:0]  signed_val;
  logic                           accept;
  logic                           take;
  logic                           from_zero;

  // restart on a first byte
  always_comb begin
    if (first_char) begin
      eff.phase    = tip_pkg::PH_SPACE;
      eff.negative = 1'b0;
      eff.base     = number_base;
      acc_e        = '0;
      cnt_e        = '0;
    end else begin
      eff   = ctrl;
      acc_e = acc;
      cnt_e = cnt;
    end
  end

  assign cnt_p1 = (cnt_e == COUNT_MAX) ? cnt_e : cnt_e + 1'b1;
  assign cnt_p2 = (cnt_p1 == COUNT_MAX) ? cnt_p1 : cnt_p1 + 1'b1;

  assign prefix_base = (eff.base == tip_pkg::BASE_AUTO) ? tip_pkg::BASE_DEC : eff.base;
  assign zero_base   = (eff.base == tip_pkg::BASE_AUTO) ? tip_pkg::BASE_OCT : eff.base;

  // radix used when this byte is taken as a digit
  always_comb begin
    case (eff.phase)
      tip_pkg::PH_SPACE:  dig_base = prefix_base;
      tip_pkg::PH_PREFIX: dig_base = prefix_base;
      tip_pkg::PH_ZERO:   dig_base = zero_base;
      default:            dig_base = eff.base;
    endcase
  end

  assign dg     = tip_pkg::digit_of(char_in);
  assign accept = dg.alnum && (dg.value < dig_base);
  assign prod   = (VALUE_WIDTH + 6)'(acc_e) * (VALUE_WIDTH + 6)'(dig_base);
  assign mac    = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dg.value);

  assign signed_val   = eff.negative ? -acc_e : acc_e;
  assign parsed_value = tip_pkg::RESULT_WIDTH'(signed_val);

  always_comb begin
    ctrl_next      = eff;
    acc_next       = acc_e;
    cnt_next       = cnt_e;
    emit           = 1'b0;
    take           = 1'b0;
    from_zero      = 1'b0;
    chars_consumed = cnt_e;

    case (eff.phase)
      tip_pkg::PH_SPACE: begin
        if (char_in == tip_pkg::CH_SPACE || char_in == tip_pkg::CH_TAB) begin
          cnt_next = cnt_p1;
        end else if (char_in == tip_pkg::CH_PLUS || char_in == tip_pkg::CH_MINUS) begin
          ctrl_next.negative = (char_in == tip_pkg::CH_MINUS);
          ctrl_next.phase    = tip_pkg::PH_PREFIX;
          cnt_next           = cnt_p1;
        end else if ((eff.base == tip_pkg::BASE_AUTO || eff.base == tip_pkg::BASE_HEX) &&
                     char_in == tip_pkg::CH_ZERO) begin
          ctrl_next.phase = tip_pkg::PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      tip_pkg::PH_PREFIX: begin
        if ((eff.base == tip_pkg::BASE_AUTO || eff.base == tip_pkg::BASE_HEX) &&
            char_in == tip_pkg::CH_ZERO) begin
          ctrl_next.phase = tip_pkg::PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      tip_pkg::PH_ZERO: begin
        if (char_in == tip_pkg::CH_X) begin
          ctrl_next.base  = tip_pkg::BASE_HEX;
          ctrl_next.phase = tip_pkg::PH_DIGITS;
          cnt_next        = cnt_p2;
        end else begin
          take      = 1'b1;
          from_zero = 1'b1;
        end
      end
      tip_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (take) begin
      ctrl_next.base  = dig_base;
      ctrl_next.phase = tip_pkg::PH_DIGITS;
      chars_consumed  = from_zero ? cnt_p1 : cnt_e;
      if (accept) begin
        acc_next = mac;
        cnt_next = from_zero ? cnt_p2 : cnt_p1;
      end else begin
        emit            = 1'b1;
        ctrl_next.phase = tip_pkg::PH_DONE;
        cnt_next        = chars_consumed;
      end
    end
  end

endmodule

// ----- hw/rtl/text_to_integer_parser_core.sv -----
// text_to_integer_parser_core: top level of the streaming text to integer parser.
// Depends on tip_pkg, tip_cfg_regs and tip_step_logic.
//
// Usage: bytes of text enter on the s_* stream, one byte per request, with
// s_tuser high on the first byte of each string. Leading blanks, one sign and
// an optional 0x or leading 0 prefix are taken, then digits below the radix.
// The first byte that is not taken produces one result request on m_*:
// the signed value (wrapping) and the count of bytes consumed (saturating).
// Further bytes are dropped until the next first byte. number_base is set
// through the APB port at address 0 and is sampled on each first byte.
// A byte enters an input register and is processed once m_tvalid is low or
// m_tready is high; its result is loaded into the output register at the end of
// that cycle, so m_tvalid rises once its stopping byte has passed both registers.
// Throughput: one byte per cycle unless m_tready holds a result, limited by the
// single 64 by 6 bit multiply-add that updates the accumulator from itself.
// Reset clears the parse (all bytes ignored until a first byte), the stored
// byte and any pending result; number_base returns to 0 (automatic).
// When m_tready is low with a result waiting, the byte in the input register
// waits and s_tready falls once that register is full.
module text_to_integer_parser_core #(
  parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = tip_pkg::COUNT_WIDTH_DEF,
  localparam int OUT_BITS   = ((tip_pkg::RESULT_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // char_in
  input  logic                           s_tuser,   // first_char
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [OUT_BITS-1:0]            m_tdata,   // parsed_value, chars_consumed
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tip_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tip_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tip_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);

  logic [tip_pkg::BASE_WIDTH-1:0]   number_base;
  logic                             in_valid;
  logic [7:0]                       in_char;
  logic                             in_first;
  logic                             fire;
  tip_pkg::ctrl_t                   ctrl;
  tip_pkg::ctrl_t                   ctrl_next;
  logic [VALUE_WIDTH-1:0]           acc;
  logic [VALUE_WIDTH-1:0]           acc_next;
  logic [COUNT_WIDTH-1:0]           cnt;
  logic [COUNT_WIDTH-1:0]           cnt_next;
  logic                             emit;
  logic [tip_pkg::RESULT_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0]           res_count;
  logic [tip_pkg::RESULT_WIDTH-1:0] out_value;
  logic [COUNT_WIDTH-1:0]           out_count;

  tip_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .number_base (number_base)
  );

  tip_step_logic #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .char_in        (in_char),
    .first_char     (in_first),
    .number_base    (number_base),
    .ctrl           (ctrl),
    .acc            (acc),
    .cnt            (cnt),
    .ctrl_next      (ctrl_next),
    .acc_next       (acc_next),
    .cnt_next       (cnt_next),
    .emit           (emit),
    .parsed_value   (res_value),
    .chars_consumed (res_count)
  );

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign m_tdata  = OUT_BITS'({out_count, out_value});

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase    <= tip_pkg::PH_DONE;
      ctrl.negative <= 1'b0;
      ctrl.base     <= tip_pkg::BASE_AUTO;
      acc           <= '0;
      cnt           <= '0;
    end else if (fire) begin
      ctrl <= ctrl_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_value <= res_value;
      out_count <= res_count;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> m_tvalid)
    else $error("emitted result not presented");

  a_result_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire) && $past(emit))
    else $error("result appeared without an emitting byte");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_char) && $stable(in_first))
    else $error("stalled input byte lost");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(fire) |-> $stable(ctrl) && $stable(acc) && $stable(cnt))
    else $error("parse state changed without a byte");
`endif

endmodule
